### src/rrip_pkg.sv
// ----------------------------------------------------------------------------
// rrip_pkg
// shared types and constants for the rrip replacement-state block
// ----------------------------------------------------------------------------
package rrip_pkg;

   localparam int DEF_NUM_SETS = 64;
   localparam int DEF_NUM_WAYS = 16;

   localparam int SET_FIELD_W    = 6;
   localparam int WAY_FIELD_W    = 4;
   localparam int CHANCE_W       = 7;
   localparam int RRPV_W         = 2;

   localparam logic [RRPV_W-1:0]   RRPV_MAX      = 2'd3;
   localparam logic [RRPV_W-1:0]   RRPV_NEAR     = 2'd1;
   localparam logic [RRPV_W-1:0]   RRPV_ZERO     = 2'd0;
   localparam logic [CHANCE_W-1:0] BIMODAL_LIMIT = 7'd5;

   localparam logic MODE_STATIC  = 1'b0;
   localparam logic MODE_BIMODAL = 1'b1;

   typedef enum logic [1:0] {
      REQ_INVALIDATE = 2'd0,
      REQ_HIT        = 2'd1,
      REQ_FILL       = 2'd2,
      REQ_VICTIM     = 2'd3
   } req_kind_type;

   // request as it travels from the accept stage to the update stage
   typedef struct packed {
      req_kind_type            kind;
      logic [WAY_FIELD_W-1:0]  way;
      logic [CHANCE_W-1:0]     chance;
      logic                    set_ok;
      logic                    mode;
   } rrip_op_type;

endpackage

### src/rrip_row_ram.sv
// ----------------------------------------------------------------------------
// rrip_row_ram
// one-row-per-set storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module rrip_row_ram import rrip_pkg::*; #(
   parameter int NUM_SETS = DEF_NUM_SETS,
   parameter int ROW_W    = DEF_NUM_WAYS * RRPV_W,
   parameter int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
   input  logic             clock,
   input  logic [SET_W-1:0] rd_addr,
   output logic [ROW_W-1:0] rd_data,
   input  logic             wr_en,
   input  logic [SET_W-1:0] wr_addr,
   input  logic [ROW_W-1:0] wr_data
);

   logic [ROW_W-1:0] mem [NUM_SETS];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read returns the old row on a same-cycle write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/rrip_row_update.sv
// ----------------------------------------------------------------------------
// rrip_row_update
// modifies one set row for a request and finds the victim way of the row
// ----------------------------------------------------------------------------
module rrip_row_update import rrip_pkg::*; #(
   parameter int NUM_WAYS = DEF_NUM_WAYS,
   parameter int ROW_W    = NUM_WAYS * RRPV_W
) (
   input  rrip_op_type            op,
   input  logic [ROW_W-1:0]       row_in,
   output logic [ROW_W-1:0]       row_out,
   output logic                   wr_needed,
   output logic [WAY_FIELD_W-1:0] victim_way
);

   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

   logic [RRPV_W-1:0]   ins_val;
   logic [RRPV_W-1:0]   cur_val;
   logic [RRPV_W-1:0]   nxt_val;
   logic                way_ok;
   logic [NUM_WAYS-1:0] at3;
   logic [NUM_WAYS-1:0] at2;
   logic [NUM_WAYS-1:0] at1;
   logic [NUM_WAYS-1:0] pick;
   logic [NUM_WAYS-1:0] lowest;
   logic [WAY_W-1:0]    enc;

   always_comb begin
      if (op.mode == MODE_BIMODAL && op.chance >= BIMODAL_LIMIT) begin
         ins_val = RRPV_MAX;
      end else begin
         ins_val = RRPV_NEAR;
      end
   end

   assign way_ok    = int'(op.way) < NUM_WAYS;
   assign wr_needed = op.set_ok && way_ok && (op.kind != REQ_VICTIM);

   always_comb begin
      row_out = row_in;
      at3     = '0;
      at2     = '0;
      at1     = '0;
      cur_val = RRPV_ZERO;
      nxt_val = RRPV_ZERO;
      for (int w = 0; w < NUM_WAYS; w++) begin
         cur_val = row_in[w*RRPV_W +: RRPV_W];
         at3[w]  = cur_val == 2'd3;
         at2[w]  = cur_val == 2'd2;
         at1[w]  = cur_val == 2'd1;
         nxt_val = cur_val;
         if (int'(op.way) == w) begin
            unique case (op.kind)
               REQ_INVALIDATE: nxt_val = RRPV_MAX;
               REQ_HIT:        nxt_val = (cur_val != RRPV_ZERO) ? cur_val - 2'd1 : cur_val;
               REQ_FILL:       nxt_val = ins_val;
               REQ_VICTIM:     nxt_val = cur_val;
               default:        nxt_val = cur_val;
            endcase
         end
         row_out[w*RRPV_W +: RRPV_W] = nxt_val;
      end
   end

   // ways at the highest present level, then the lowest of them
   always_comb begin
      priority if (|at3) begin
         pick = at3;
      end else if (|at2) begin
         pick = at2;
      end else if (|at1) begin
         pick = at1;
      end else begin
         pick = '1;
      end
   end

   assign lowest = pick & ((~pick) + NUM_WAYS'(1));

   always_comb begin
      enc = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (lowest[w]) begin
            enc = enc | WAY_W'(w);
         end
      end
   end

   assign victim_way = op.set_ok ? WAY_FIELD_W'(enc) : '0;

endmodule

### src/rrip_replacement_policy_top.sv
// ----------------------------------------------------------------------------
// rrip_replacement_policy_top
// 2-bit re-reference value tracking per way with victim selection
// ----------------------------------------------------------------------------
// usage
//   request channel: a word on req_type, req_set_index, req_way_index and
//   req_chance is taken at a rising edge where start is high and busy is low.
//   invalidate, hit and fill update the addressed way and give no response.
//   a victim request gives one response word on rsp_victim_way, marked by
//   rsp_valid for exactly one cycle.
//   config channel: csr_insertion_mode is written when csr_valid and
//   csr_ready are high (csr_ready is always high); 0 static insertion at 1,
//   1 bimodal insertion; write only while no request is in flight.
//   pipeline: a taken request reads its set row at the accepting edge into
//   the update stage, which applies it and writes the row back; a victim
//   response then passes the response register to the rsp ports.
//   throughput: one request per cycle while busy is low; a request on the set
//   that is being written back as it is taken gets the written row from a
//   forwarding register, so there is no interlock.
//   reset: synchronous; afterwards a clearing pass writes every set row to
//   all-3 at one row per cycle, and busy stays high until the last is written.
//   the receiver cannot stall: responses are strobes and are never held.
// ----------------------------------------------------------------------------
module rrip_replacement_policy_top import rrip_pkg::*; #(
   parameter int NUM_SETS = DEF_NUM_SETS,
   parameter int NUM_WAYS = DEF_NUM_WAYS
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_type,
   input  logic [SET_FIELD_W-1:0] req_set_index,
   input  logic [WAY_FIELD_W-1:0] req_way_index,
   input  logic [CHANCE_W-1:0]    req_chance,
   // response channel
   output logic                   rsp_valid,
   output logic [WAY_FIELD_W-1:0] rsp_victim_way,
   // config channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_insertion_mode
);

   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int ROW_W = NUM_WAYS * RRPV_W;

   // all ways at the insertion-distant value
   localparam logic [ROW_W-1:0] ROW_RESET = {NUM_WAYS{RRPV_MAX}};

   logic                   accept;
   logic                   csr_write;
   logic [SET_W-1:0]       rd_addr;
   logic [ROW_W-1:0]       rd_row;
   logic [ROW_W-1:0]       cur_row;
   logic [ROW_W-1:0]       upd_row;
   logic                   upd_wr;
   logic [WAY_FIELD_W-1:0] upd_victim;
   rrip_op_type            acc_op;

   logic                   wr_en;
   logic [SET_W-1:0]       wr_addr;
   logic [ROW_W-1:0]       wr_data;

   // config register
   logic                   mode_ff;
   logic                   mode_in;

   // clearing pass after reset
   logic                   clear_ff;
   logic                   clear_in;
   logic [SET_W-1:0]       clear_cnt_ff;
   logic [SET_W-1:0]       clear_cnt_in;

   // update stage
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   rrip_op_type            s1_op_ff;
   rrip_op_type            s1_op_in;
   logic [SET_W-1:0]       s1_addr_ff;
   logic [SET_W-1:0]       s1_addr_in;

   // last write, for a read that raced with it
   logic                   fwd_valid_ff;
   logic                   fwd_valid_in;
   logic [SET_W-1:0]       fwd_addr_ff;
   logic [SET_W-1:0]       fwd_addr_in;
   logic [ROW_W-1:0]       fwd_row_ff;
   logic [ROW_W-1:0]       fwd_row_in;

   // response register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [WAY_FIELD_W-1:0] rsp_way_ff;
   logic [WAY_FIELD_W-1:0] rsp_way_in;

   assign busy      = clear_ff;
   assign accept    = start && !clear_ff;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // the row is read straight from the request word at the accepting edge
   assign rd_addr = SET_W'(req_set_index);

   always_comb begin
      acc_op.kind   = req_kind_type'(req_type);
      acc_op.way    = req_way_index;
      acc_op.chance = req_chance;
      acc_op.set_ok = int'(req_set_index) < NUM_SETS;
      acc_op.mode   = mode_ff;
   end

   rrip_row_ram #(
      .NUM_SETS (NUM_SETS),
      .ROW_W    (ROW_W),
      .SET_W    (SET_W)
   ) u_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_row),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // the ram returned the old row if the same set was written at the read edge
   assign cur_row = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_row_ff : rd_row;

   rrip_row_update #(
      .NUM_WAYS (NUM_WAYS),
      .ROW_W    (ROW_W)
   ) u_update (
      .op         (s1_op_ff),
      .row_in     (cur_row),
      .row_out    (upd_row),
      .wr_needed  (upd_wr),
      .victim_way (upd_victim)
   );

   // write port: clearing pass or write-back of the update stage
   always_comb begin
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_cnt_ff;
         wr_data = ROW_RESET;
      end else begin
         wr_en   = s1_valid_ff && upd_wr;
         wr_addr = s1_addr_ff;
         wr_data = upd_row;
      end
   end

   always_comb begin
      mode_in      = csr_write ? csr_insertion_mode : mode_ff;

      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + SET_W'(1);
         if (clear_cnt_ff == SET_W'(NUM_SETS - 1)) begin
            clear_in = 1'b0;
         end
      end

      s1_valid_in  = accept;
      s1_op_in     = acc_op;
      s1_addr_in   = rd_addr;

      fwd_valid_in = wr_en;
      fwd_addr_in  = wr_addr;
      fwd_row_in   = wr_data;

      rsp_valid_in = s1_valid_ff && (s1_op_ff.kind == REQ_VICTIM);
      rsp_way_in   = upd_victim;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STATIC;
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_op_ff    <= s1_op_in;
      s1_addr_ff  <= s1_addr_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_row_ff  <= fwd_row_in;
      rsp_way_ff  <= rsp_way_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;

endmodule

### tb/sv/tb_rrip_replacement_policy_top.sv
// ----------------------------------------------------------------------------
// tb_rrip_replacement_policy_top
// self-checking bench for the rrip replacement-state block: a directed table
// covers reset state, ties, saturation and both insertion modes, then random
// request words in several idle phases are checked against a shadow model
// ----------------------------------------------------------------------------
module tb_rrip_replacement_policy_top;
   import rrip_pkg::*;

   localparam int PLAN_LEN  = 23;
   localparam int PHASES    = 4;
   localparam int PHASE_LEN = 500;

   // dut ports; the inputs are all driven from time zero
   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   start              = 1'b0;
   logic                   busy;
   logic [1:0]             req_type           = REQ_INVALIDATE;
   logic [SET_FIELD_W-1:0] req_set_index      = '0;
   logic [WAY_FIELD_W-1:0] req_way_index      = '0;
   logic [CHANCE_W-1:0]    req_chance         = '0;
   logic                   rsp_valid;
   logic [WAY_FIELD_W-1:0] rsp_victim_way;
   logic                   csr_valid          = 1'b0;
   logic                   csr_ready;
   logic                   csr_insertion_mode = MODE_STATIC;

   // shadow of the replacement state and of the mode register
   logic [RRPV_W-1:0]      rrpv_shadow [DEF_NUM_SETS][DEF_NUM_WAYS];
   logic                   mode_shadow;

   // victim ways still owed by the dut, oldest first
   logic [WAY_FIELD_W-1:0] victim_way_due [$];
   logic [WAY_FIELD_W-1:0] due_way;
   int unsigned            mismatch_count = 0;

   // start is lowered only by the driver; this tracks what it last scheduled
   logic                   start_held = 1'b0;

   // one row of the directed plan: either a mode write or a request word
   typedef struct {
      logic                   is_cfg;
      logic                   cfg_mode;
      req_kind_type           kind;
      logic [SET_FIELD_W-1:0] set_idx;
      logic [WAY_FIELD_W-1:0] way_idx;
      logic [CHANCE_W-1:0]    chance;
      logic                   known;
      logic [WAY_FIELD_W-1:0] want;
   } plan_row_type;

   plan_row_type plan [PLAN_LEN] = '{
      // fresh store: every way ties at 3, so the victim is way 0
      '{1'b0, MODE_STATIC,  REQ_VICTIM,     6'd0,  4'd0,  7'd0,   1'b1, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_VICTIM,     6'd63, 4'd15, 7'd127, 1'b1, 4'd0},
      // way 0 drops below the rest, victim moves to way 1
      '{1'b0, MODE_STATIC,  REQ_HIT,        6'd0,  4'd0,  7'd0,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_VICTIM,     6'd0,  4'd0,  7'd0,   1'b0, 4'd0},
      // four hits on the top way: 3 2 1 0 and then held at 0
      '{1'b0, MODE_STATIC,  REQ_HIT,        6'd5,  4'd15, 7'd0,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_HIT,        6'd5,  4'd15, 7'd0,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_HIT,        6'd5,  4'd15, 7'd0,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_HIT,        6'd5,  4'd15, 7'd0,   1'b0, 4'd0},
      // static fill ignores the chance field, even one above 99
      '{1'b0, MODE_STATIC,  REQ_FILL,       6'd5,  4'd0,  7'd127, 1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_VICTIM,     6'd5,  4'd0,  7'd0,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_INVALIDATE, 6'd0,  4'd0,  7'd0,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_VICTIM,     6'd0,  4'd0,  7'd0,   1'b0, 4'd0},
      // bimodal: chance edges at 4 and 5, top of range and out of range
      '{1'b1, MODE_BIMODAL, REQ_INVALIDATE, 6'd0,  4'd0,  7'd0,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_FILL,       6'd10, 4'd3,  7'd4,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_FILL,       6'd10, 4'd4,  7'd5,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_FILL,       6'd10, 4'd5,  7'd99,  1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_FILL,       6'd10, 4'd6,  7'd127, 1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_FILL,       6'd10, 4'd0,  7'd0,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_VICTIM,     6'd10, 4'd0,  7'd0,   1'b0, 4'd0},
      // back to static, all-ones fields on the last set and way
      '{1'b1, MODE_STATIC,  REQ_INVALIDATE, 6'd0,  4'd0,  7'd0,   1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_FILL,       6'd63, 4'd15, 7'd127, 1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_HIT,        6'd63, 4'd15, 7'd127, 1'b0, 4'd0},
      '{1'b0, MODE_STATIC,  REQ_VICTIM,     6'd63, 4'd15, 7'd127, 1'b0, 4'd0}
   };

   rrip_replacement_policy_top u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_set_index      (req_set_index),
      .req_way_index      (req_way_index),
      .req_chance         (req_chance),
      .rsp_valid          (rsp_valid),
      .rsp_victim_way     (rsp_victim_way),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_insertion_mode (csr_insertion_mode)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // shadow model
   // ------------------------------------------------------------------

   // lowest way holding the greatest value; ties keep the lower way
   function automatic logic [WAY_FIELD_W-1:0] predict_victim_way(
      input logic [SET_FIELD_W-1:0] set_idx
   );
      logic [WAY_FIELD_W-1:0] best_way;
      logic [RRPV_W-1:0]      best_val;
      best_way = '0;
      best_val = RRPV_ZERO;
      if (set_idx >= DEF_NUM_SETS) return '0;
      for (int w = 0; w < DEF_NUM_WAYS; w++) begin
         if (w == 0 || rrpv_shadow[set_idx][w] > best_val) begin
            best_val = rrpv_shadow[set_idx][w];
            best_way = WAY_FIELD_W'(w);
         end
      end
      return best_way;
   endfunction

   function automatic void apply_rrpv_update(
      input req_kind_type           kind,
      input logic [SET_FIELD_W-1:0] set_idx,
      input logic [WAY_FIELD_W-1:0] way_idx,
      input logic [CHANCE_W-1:0]    chance
   );
      if (set_idx >= DEF_NUM_SETS || way_idx >= DEF_NUM_WAYS) return;
      unique case (kind)
         REQ_INVALIDATE: begin
            rrpv_shadow[set_idx][way_idx] = RRPV_MAX;
         end
         REQ_HIT: begin
            // saturating decrement
            if (rrpv_shadow[set_idx][way_idx] != RRPV_ZERO)
               rrpv_shadow[set_idx][way_idx] = rrpv_shadow[set_idx][way_idx] - 2'd1;
         end
         REQ_FILL: begin
            if (mode_shadow == MODE_STATIC || chance < BIMODAL_LIMIT)
               rrpv_shadow[set_idx][way_idx] = RRPV_NEAR;
            else
               rrpv_shadow[set_idx][way_idx] = RRPV_MAX;
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // driver tasks
   // ------------------------------------------------------------------

   // present one request word, wait for it to be taken, then for a nonzero
   // gap idle with junk on the fields; a known expectation overrides the model
   task automatic send_request(
      input req_kind_type           kind,
      input logic [SET_FIELD_W-1:0] set_idx,
      input logic [WAY_FIELD_W-1:0] way_idx,
      input logic [CHANCE_W-1:0]    chance,
      input logic                   known,
      input logic [WAY_FIELD_W-1:0] want,
      input int unsigned            gap
   );
      start         <= 1'b1;
      start_held     = 1'b1;
      req_type      <= kind;
      req_set_index <= set_idx;
      req_way_index <= way_idx;
      req_chance    <= chance;
      do @(posedge clock); while (busy !== 1'b0);
      // word taken at this edge: advance the shadow in issue order
      if (kind == REQ_VICTIM)
         victim_way_due.push_back(known ? want : predict_victim_way(set_idx));
      else
         apply_rrpv_update(kind, set_idx, way_idx, chance);
      if (gap != 0) begin
         start      <= 1'b0;
         start_held  = 1'b0;
         repeat (gap) begin
            req_type      <= req_kind_type'($urandom_range(3));
            req_set_index <= SET_FIELD_W'($urandom);
            req_way_index <= WAY_FIELD_W'($urandom);
            req_chance    <= CHANCE_W'($urandom);
            @(posedge clock);
         end
      end
   endtask

   // stop issuing, let every owed victim come back and the pipe empty out
   task automatic settle_idle();
      if (start_held) begin
         start      <= 1'b0;
         start_held  = 1'b0;
      end
      while (victim_way_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_insertion_mode(input logic mode);
      csr_valid          <= 1'b1;
      csr_insertion_mode <= mode;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid   <= 1'b0;
      mode_shadow  = mode;
   endtask

   // random word: mostly hits and fills on two hot sets so values spread
   // out, plus victims on those sets and some traffic over the whole range
   task automatic send_random_word(
      input int unsigned            idle_pct,
      input logic [SET_FIELD_W-1:0] hot0,
      input logic [SET_FIELD_W-1:0] hot1
   );
      req_kind_type           kind;
      logic [SET_FIELD_W-1:0] set_idx;
      logic [CHANCE_W-1:0]    chance;
      int unsigned            pick;
      int unsigned            gap;
      pick = $urandom_range(99);
      if (pick < 15)      kind = REQ_INVALIDATE;
      else if (pick < 50) kind = REQ_HIT;
      else if (pick < 75) kind = REQ_FILL;
      else                kind = REQ_VICTIM;
      pick = $urandom_range(99);
      if (pick < 40)      set_idx = hot0;
      else if (pick < 80) set_idx = hot1;
      else                set_idx = SET_FIELD_W'($urandom);
      // keep the bimodal threshold busy, but still reach the full field
      chance = $urandom_range(1) ? CHANCE_W'($urandom_range(9)) : CHANCE_W'($urandom);
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      send_request(kind, set_idx, WAY_FIELD_W'($urandom), chance, 1'b0, '0, gap);
   endtask

   // ------------------------------------------------------------------
   // response checker: rsp_valid is a one-cycle strobe, sampled at the
   // edge that ends its cycle
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (victim_way_due.size() == 0) begin
            $display("%0t: victim_way expected no word got %0d", $time, rsp_victim_way);
            mismatch_count++;
         end else begin
            due_way = victim_way_due.pop_front();
            if (rsp_victim_way !== due_way) begin
               $display("%0t: victim_way expected %0d got %0d",
                        $time, due_way, rsp_victim_way);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned            idle_by_phase [PHASES];
      logic                   mode_by_phase [PHASES];
      logic [SET_FIELD_W-1:0] hot0;
      logic [SET_FIELD_W-1:0] hot1;

      // no idling, heavy sender idling, no idling, light idling
      idle_by_phase = '{0, 78, 0, 14};
      mode_by_phase = '{MODE_BIMODAL, MODE_STATIC, MODE_BIMODAL, MODE_STATIC};

      // shadow starts from the reset state: every way at 3, static mode
      for (int s = 0; s < DEF_NUM_SETS; s++)
         for (int w = 0; w < DEF_NUM_WAYS; w++)
            rrpv_shadow[s][w] = RRPV_MAX;
      mode_shadow = MODE_STATIC;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // the mode register is independent of the clearing pass
      write_insertion_mode(MODE_STATIC);

      // directed plan; busy covers the clearing pass on the first word
      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].is_cfg) begin
            settle_idle();
            write_insertion_mode(plan[i].cfg_mode);
         end else begin
            send_request(plan[i].kind, plan[i].set_idx, plan[i].way_idx, plan[i].chance,
                         plan[i].known, plan[i].want, $urandom_range(2));
         end
      end

      // random phases, each under its own mode and idle pattern
      for (int p = 0; p < PHASES; p++) begin
         settle_idle();
         write_insertion_mode(mode_by_phase[p]);
         hot0 = SET_FIELD_W'($urandom);
         hot1 = SET_FIELD_W'($urandom);
         for (int n = 0; n < PHASE_LEN; n++)
            send_random_word(idle_by_phase[p], hot0, hot1);
      end

      // drain and give the pipe a few more cycles for stray strobes
      settle_idle();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
